@@ sv/line_rasterizer_defines.svh @@
// Assertion macros shared by the line rasterizer modules.
// Each macro expects signals named clk and rst in the including module.
`ifndef LINE_RASTERIZER_DEFINES_SVH
`define LINE_RASTERIZER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define LR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/lr_pkg.sv @@
// Package for the line rasterizer: command codes and the control struct
// that travels from the front end through the command queue. No dependencies.
package lr_pkg;

  localparam int COLOR_BITS = 32;

  typedef enum logic [0:0] {
    ACT_BEGIN = 1'b0,
    ACT_STEP  = 1'b1
  } action_t;

  typedef struct packed {
    action_t action;
    logic    steep;
    logic    minor_down;
  } lr_ctl_t;

endpackage

@@ sv/lr_front.sv @@
// Front end of the line rasterizer: classifies input items and sets up a
// new line (axis swap, endpoint ordering, spans). Depends on lr_pkg.
module lr_front #(
  parameter int COORD_BITS = 12
) (
  input  logic                          action,
  input  logic [COORD_BITS-1:0]         x_start,
  input  logic [COORD_BITS-1:0]         y_start,
  input  logic [COORD_BITS-1:0]         x_end,
  input  logic [COORD_BITS-1:0]         y_end,
  output lr_pkg::lr_ctl_t               ctl,
  output logic [COORD_BITS-1:0]         major_pos,
  output logic [COORD_BITS-1:0]         major_end,
  output logic [COORD_BITS-1:0]         minor_pos,
  output logic [COORD_BITS-1:0]         major_span,
  output logic [COORD_BITS:0]           minor_step2
);

  logic [COORD_BITS-1:0] dx, dy;
  logic [COORD_BITS-1:0] a0, a1, b0, b1;
  logic [COORD_BITS-1:0] minor_first, minor_last;
  logic                  steep, reverse;

  always_comb begin
    dx    = (x_start > x_end) ? (x_start - x_end) : (x_end - x_start);
    dy    = (y_start > y_end) ? (y_start - y_end) : (y_end - y_start);
    steep = dx < dy;

    a0 = steep ? y_start : x_start;
    a1 = steep ? y_end   : x_end;
    b0 = steep ? x_start : y_start;
    b1 = steep ? x_end   : y_end;

    // Walk the major axis upward.
    reverse     = a0 > a1;
    major_pos   = reverse ? a1 : a0;
    major_end   = reverse ? a0 : a1;
    minor_first = reverse ? b1 : b0;
    minor_last  = reverse ? b0 : b1;

    // The spans are the two absolute differences, picked by the swap.
    major_span  = steep ? dy : dx;
    minor_step2 = {(steep ? dx : dy), 1'b0};
    minor_pos   = minor_first;

    ctl.action     = lr_pkg::action_t'(action);
    ctl.steep      = steep;
    ctl.minor_down = minor_last < minor_first;
  end

endmodule

@@ sv/lr_queue.sv @@
// Short command queue between the line rasterizer front and back ends.
// Register-based FIFO with a fall-through read port. Uses the assertion header.
`include "line_rasterizer_defines.svh"

module lr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `LR_ASSERT_NOW(a_no_overflow, full, !push, "push into a full command queue")
  `LR_ASSERT_NOW(a_no_underflow, !not_empty, !pop, "pop from an empty command queue")
  `LR_ASSERT_NEXT(a_pop_drains, (pop && !push && count == CNT_W'(1)), !not_empty,
    "queue not empty after its last entry was popped")

endmodule

@@ sv/lr_back.sv @@
// Back end of the line rasterizer: holds the line state, runs one Bresenham
// step per step command of a running line and drives the registered pixel output. Depends on lr_pkg.
`include "line_rasterizer_defines.svh"

module lr_back #(
  parameter int COORD_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_pop,
  input  lr_pkg::lr_ctl_t               cmd_ctl,
  input  logic [COORD_BITS-1:0]         cmd_major_pos,
  input  logic [COORD_BITS-1:0]         cmd_major_end,
  input  logic [COORD_BITS-1:0]         cmd_minor_pos,
  input  logic [COORD_BITS-1:0]         cmd_major_span,
  input  logic [COORD_BITS:0]           cmd_minor_step2,
  input  logic [lr_pkg::COLOR_BITS-1:0] cmd_color,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [COORD_BITS-1:0]         pixel_x,
  output logic [COORD_BITS-1:0]         pixel_y,
  output logic [lr_pkg::COLOR_BITS-1:0] pixel_color,
  output logic                          last_pixel
);

  localparam int EW = COORD_BITS + 3;

  logic                          busy;
  logic                          steep;
  logic [COORD_BITS-1:0]         major_pos;
  logic [COORD_BITS-1:0]         major_end;
  logic [COORD_BITS-1:0]         minor_pos;
  logic                          minor_down;
  logic [COORD_BITS-1:0]         major_span;
  logic [COORD_BITS:0]           minor_step2;
  logic [COORD_BITS+1:0]         error_acc;
  logic [lr_pkg::COLOR_BITS-1:0] held_color;

  logic                 is_begin, do_pixel, at_end, minor_move;
  logic signed [EW-1:0] e_sum, span_ext, e_next;

  always_comb begin
    is_begin = (cmd_ctl.action == lr_pkg::ACT_BEGIN);
    cmd_pop  = cmd_valid && (is_begin || !out_valid || out_ready);
    do_pixel = cmd_pop && !is_begin && busy;
    at_end   = (major_pos == major_end);

    e_sum      = $signed({error_acc[COORD_BITS+1], error_acc})
               + $signed({2'b00, minor_step2});
    span_ext   = $signed({3'b000, major_span});
    minor_move = e_sum > span_ext;
    e_next     = minor_move ? (e_sum - (span_ext <<< 1)) : e_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd_pop && is_begin) begin
        busy <= 1'b1;
      end else if (do_pixel) begin
        out_valid <= 1'b1;
        if (at_end) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && is_begin) begin
      steep       <= cmd_ctl.steep;
      major_pos   <= cmd_major_pos;
      major_end   <= cmd_major_end;
      minor_pos   <= cmd_minor_pos;
      minor_down  <= cmd_ctl.minor_down;
      major_span  <= cmd_major_span;
      minor_step2 <= cmd_minor_step2;
      error_acc   <= '0;
      held_color  <= cmd_color;
    end else if (do_pixel) begin
      pixel_x     <= steep ? minor_pos : major_pos;
      pixel_y     <= steep ? major_pos : minor_pos;
      pixel_color <= held_color;
      last_pixel  <= at_end;
      if (!at_end) begin
        if (minor_move) begin
          minor_pos <= minor_down ? (minor_pos - 1'b1) : (minor_pos + 1'b1);
        end
        error_acc <= e_next[COORD_BITS+1:0];
        major_pos <= major_pos + 1'b1;
      end
    end
  end

  `LR_ASSERT_NOW(a_major_bound, busy, (major_pos <= major_end),
    "major coordinate ran past the line end")
  `LR_ASSERT_NOW(a_error_range, busy,
    (($signed(error_acc) >= -$signed({2'b00, major_span}))
      && ($signed(error_acc) <= $signed({2'b00, major_span}))),
    "error term left its range")
  `LR_ASSERT_NEXT(a_last_idles, (do_pixel && at_end), !busy,
    "engine still busy after the last pixel")
  `LR_ASSERT_NEXT(a_idle_step_silent, (cmd_pop && !is_begin && !busy), !out_valid,
    "step while idle produced a pixel")

endmodule

@@ sv/line_rasterizer.sv @@
// Top level of the Bresenham line rasterizer: front end, command queue and
// back end. Depends on lr_pkg, lr_front, lr_queue and lr_back.
//
//  Channel  Direction  Handshake             Payload
//  in       input      in_valid / in_ready   action, x_start, y_start, x_end, y_end, pen_color
//  out      output     out_valid / out_ready pixel_x, pixel_y, pixel_color, last_pixel
//
// A begin item sets up its line in the front end before it is written into a
// two-entry command queue; a step is written into the same queue, and its pixel
// is registered at the back end output when the step is popped.
// The back end retires one command per cycle unless a held pixel is not taken, so
// with out_ready high the block sustains one pixel per clock on a run of steps; the
// combinational error update in the back end allows that rate.
// in_ready depends only on the queue fill, and the output register lets a
// new command run while the previous pixel is being taken.
// Reset (rst, synchronous, active high) empties the queue, drops any line in
// progress and clears the output valid.
module line_rasterizer #(
  parameter int COORD_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic [COORD_BITS-1:0]         x_start,
  input  logic [COORD_BITS-1:0]         y_start,
  input  logic [COORD_BITS-1:0]         x_end,
  input  logic [COORD_BITS-1:0]         y_end,
  input  logic [lr_pkg::COLOR_BITS-1:0] pen_color,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [COORD_BITS-1:0]         pixel_x,
  output logic [COORD_BITS-1:0]         pixel_y,
  output logic [lr_pkg::COLOR_BITS-1:0] pixel_color,
  output logic                          last_pixel
);

  // Queue entry: control, four coordinate-wide fields, the doubled minor
  // span and the color.
  localparam int CTL_W   = $bits(lr_pkg::lr_ctl_t);
  localparam int ENTRY_W = CTL_W + 5 * COORD_BITS + 1 + lr_pkg::COLOR_BITS;

  lr_pkg::lr_ctl_t       f_ctl, q_ctl;
  logic [COORD_BITS-1:0] f_major_pos, f_major_end, f_minor_pos, f_major_span;
  logic [COORD_BITS:0]   f_minor_step2;
  logic [ENTRY_W-1:0]    push_data, pop_data;
  logic                  q_full, q_valid, q_pop, push;

  lr_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .action      (action),
    .x_start     (x_start),
    .y_start     (y_start),
    .x_end       (x_end),
    .y_end       (y_end),
    .ctl         (f_ctl),
    .major_pos   (f_major_pos),
    .major_end   (f_major_end),
    .minor_pos   (f_minor_pos),
    .major_span  (f_major_span),
    .minor_step2 (f_minor_step2)
  );

  assign in_ready  = !q_full;
  assign push      = in_valid && !q_full;
  assign push_data = {f_ctl, f_major_pos, f_major_end, f_minor_pos, f_major_span,
                      f_minor_step2, pen_color};

  lr_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (2)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (pop_data)
  );

  assign q_ctl = lr_pkg::lr_ctl_t'(pop_data[ENTRY_W-1 -: CTL_W]);

  lr_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (q_valid),
    .cmd_pop         (q_pop),
    .cmd_ctl         (q_ctl),
    .cmd_major_pos   (pop_data[ENTRY_W-CTL_W-1 -: COORD_BITS]),
    .cmd_major_end   (pop_data[ENTRY_W-CTL_W-COORD_BITS-1 -: COORD_BITS]),
    .cmd_minor_pos   (pop_data[ENTRY_W-CTL_W-2*COORD_BITS-1 -: COORD_BITS]),
    .cmd_major_span  (pop_data[ENTRY_W-CTL_W-3*COORD_BITS-1 -: COORD_BITS]),
    .cmd_minor_step2 (pop_data[lr_pkg::COLOR_BITS +: COORD_BITS+1]),
    .cmd_color       (pop_data[lr_pkg::COLOR_BITS-1:0]),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .pixel_x         (pixel_x),
    .pixel_y         (pixel_y),
    .pixel_color     (pixel_color),
    .last_pixel      (last_pixel)
  );

endmodule

@@ verif/line_rasterizer_tb.sv @@
// Self-checking testbench for the line_rasterizer Bresenham line engine.
// It has its own line predictor and drives random valid/ready traffic on both channels.
// Depends on lr_pkg and the line_rasterizer RTL.
`timescale 1ns / 100ps

module line_rasterizer_tb;
  import lr_pkg::*;

  localparam int CW = 12;
  localparam int CMAX = (1 << CW) - 1;
  // A pixel is offered once its step has passed the command queue and the output
  // register, so DRAIN_CYCLES of quiet after the last expected pixel is plenty to catch a stray one.
  localparam int DRAIN_CYCLES = 40;
  localparam int TIMEOUT_NS = 2_000_000;

  // One input transfer, as the sender sees it.
  typedef struct {
    action_t         act;
    logic [CW-1:0]   x0;
    logic [CW-1:0]   y0;
    logic [CW-1:0]   x1;
    logic [CW-1:0]   y1;
    logic [31:0]     color;
  } line_cmd_t;

  // One output transfer, as the predictor expects it.
  typedef struct {
    logic [CW-1:0] px;
    logic [CW-1:0] py;
    logic [31:0]   color;
    logic          last;
  } pixel_t;

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_ready;
  action_t       action;
  logic [CW-1:0] x_start;
  logic [CW-1:0] y_start;
  logic [CW-1:0] x_end;
  logic [CW-1:0] y_end;
  logic [31:0]   pen_color;
  logic          out_valid;
  logic          out_ready;
  logic [CW-1:0] pixel_x;
  logic [CW-1:0] pixel_y;
  logic [31:0]   pixel_color;
  logic          last_pixel;

  line_rasterizer #(
    .COORD_BITS(CW)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .x_start    (x_start),
    .y_start    (y_start),
    .x_end      (x_end),
    .y_end      (y_end),
    .pen_color  (pen_color),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .pixel_color(pixel_color),
    .last_pixel (last_pixel)
  );

  // Predictor copy of the line engine state.
  logic          ln_busy;
  logic          ln_steep;
  logic          ln_down;
  logic [CW-1:0] ln_major;
  logic [CW-1:0] ln_major_end;
  logic [CW-1:0] ln_minor;
  logic [CW-1:0] ln_span;
  logic [CW:0]   ln_minor2;
  int            ln_err;
  logic [31:0]   ln_color;

  pixel_t pixel_q[$];

  int send_idle_pct;
  int recv_idle_pct;
  int error_count;
  int items_sent;
  int lines_begun;
  int pixels_checked;

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver side: out_ready changes on the falling edge, stalling at the
  // rate set by the current phase.
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  function automatic logic [CW-1:0] coord_dist(input logic [CW-1:0] a, input logic [CW-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Applies one accepted input transfer to the predictor. A begin sets up
  // the line; a step while a line is running queues the pixel it must emit
  // and then moves the error term and the coordinates on.
  task automatic predict_pixel(input line_cmd_t c);
    logic [CW-1:0] a0, b0, a1, b1, t;
    pixel_t p;
    int e;
    if (c.act == ACT_BEGIN) begin
      a0 = c.x0;
      b0 = c.y0;
      a1 = c.x1;
      b1 = c.y1;
      // Steeper than 45 degrees: walk along y instead of x.
      ln_steep = coord_dist(a0, a1) < coord_dist(b0, b1);
      if (ln_steep) begin
        t = a0; a0 = b0; b0 = t;
        t = a1; a1 = b1; b1 = t;
      end
      // Order the endpoints so that the major coordinate counts up.
      if (a0 > a1) begin
        t = a0; a0 = a1; a1 = t;
        t = b0; b0 = b1; b1 = t;
      end
      ln_major     = a0;
      ln_major_end = a1;
      ln_minor     = b0;
      ln_down      = b1 < b0;
      ln_span      = a1 - a0;
      ln_minor2    = {coord_dist(b0, b1), 1'b0};
      ln_err       = 0;
      ln_color     = c.color;
      ln_busy      = 1'b1;
      lines_begun++;
    end else if (ln_busy) begin
      p.px    = ln_steep ? ln_minor : ln_major;
      p.py    = ln_steep ? ln_major : ln_minor;
      p.color = ln_color;
      p.last  = (ln_major == ln_major_end);
      pixel_q.insert(pixel_q.size(), p);
      if (p.last) begin
        ln_busy = 1'b0;
      end else begin
        e = ln_err + int'(ln_minor2);
        if (e > int'(ln_span)) begin
          ln_minor = ln_down ? ln_minor - 1'b1 : ln_minor + 1'b1;
          e -= 2 * int'(ln_span);
        end
        ln_err   = e;
        ln_major = ln_major + 1'b1;
      end
    end
  endtask

  // Output checker: every pixel transfer is matched against the oldest
  // expected pixel, field by field.
  always @(posedge clk) begin : check_pixels
    pixel_t want;
    if (!rst && out_valid && out_ready) begin
      if (pixel_q.size() == 0) begin
        report_mismatch("pixel_x of a pixel with nothing expected", 32'(pixel_x), 0);
      end else begin
        want = pixel_q.pop_front();
        if (pixel_x !== want.px) report_mismatch("pixel_x", 32'(pixel_x), 32'(want.px));
        if (pixel_y !== want.py) report_mismatch("pixel_y", 32'(pixel_y), 32'(want.py));
        if (pixel_color !== want.color) report_mismatch("pixel_color", pixel_color, want.color);
        if (last_pixel !== want.last) begin
          report_mismatch("last_pixel", 32'(last_pixel), 32'(want.last));
        end
        pixels_checked++;
      end
    end
  end

  // Sends one item. Inputs change on the falling edge; the sender may idle first.
  // in_valid stays high with the payload held until the transfer, which is seen
  // at the rising edge with in_ready high.
  task automatic send_item(input line_cmd_t c);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    action    = c.act;
    x_start   = c.x0;
    y_start   = c.y0;
    x_end     = c.x1;
    y_end     = c.y1;
    pen_color = c.color;
    in_valid  = 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_pixel(c);
    items_sent++;
  endtask

  // A step ignores its coordinate and color fields, so they carry noise.
  task automatic send_step();
    line_cmd_t c;
    c.act   = ACT_STEP;
    c.x0    = CW'($urandom);
    c.y0    = CW'($urandom);
    c.x1    = CW'($urandom);
    c.y1    = CW'($urandom);
    c.color = $urandom;
    send_item(c);
  endtask

  // Begins a line and then asks for a given number of pixels.
  task automatic draw_line(input int x0, input int y0, input int x1, input int y1,
                           input logic [31:0] color, input int steps);
    line_cmd_t c;
    c.act   = ACT_BEGIN;
    c.x0    = CW'(x0);
    c.y0    = CW'(y0);
    c.x1    = CW'(x1);
    c.y1    = CW'(y1);
    c.color = color;
    send_item(c);
    repeat (steps) send_step();
  endtask

  // Holds the sender off until every expected pixel has been taken.
  task automatic wait_for_pixels();
    @(negedge clk);
    in_valid = 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic int near_coord(input int c, input int d);
    if ($urandom_range(1)) d = -d;
    if (c + d < 0 || c + d > CMAX) d = -d;
    return c + d;
  endfunction

  task automatic test_idle_steps();
    // Steps with no line in progress must produce nothing.
    send_step();
    send_step();
  endtask

  task automatic test_point_lines();
    // A single-point line gives one pixel flagged last; the extra step
    // after it lands on an idle engine.
    draw_line(0, 0, 0, 0, 32'hFFFF_FFFF, 2);
    draw_line(CMAX, CMAX, CMAX, CMAX, 32'h0000_0000, 1);
  endtask

  task automatic test_axis_lines();
    // Horizontal line given right to left, then a vertical line at the
    // right edge; the minor coordinate must not move on either.
    draw_line(CMAX, CMAX, CMAX - 2, CMAX, 32'hA5A5_5A5A, 3);
    draw_line(CMAX, 0, CMAX, 2, 32'h5A5A_A5A5, 3);
  endtask

  task automatic test_diagonals_and_abandon();
    // Exact diagonal going down across the corner of the coordinate range.
    draw_line(0, CMAX, 3, CMAX - 3, 32'h1234_5678, 4);
    // A full-range line abandoned after two pixels by a new begin, which
    // is a steep line given bottom to top.
    draw_line(0, 0, CMAX, CMAX - 7, 32'hDEAD_BEEF, 2);
    draw_line(20, 14, 18, 10, 32'h8001_7FFE, 5);
  endtask

  // One random line: mostly short, complete lines anywhere in the range,
  // plus cut-short lines (abandoned by the next begin), lines followed by
  // steps on an idle engine, and a few full-range lines left unfinished.
  task automatic random_line();
    int x0, y0, x1, y1, len, steps, pick;
    pick = $urandom_range(99);
    x0 = $urandom_range(CMAX);
    y0 = $urandom_range(CMAX);
    if (pick < 4) begin
      x1 = $urandom_range(CMAX);
      y1 = $urandom_range(CMAX);
      steps = $urandom_range(1, 6);
    end else begin
      x1 = near_coord(x0, ($urandom_range(5) == 0) ? 0 : $urandom_range(12));
      y1 = near_coord(y0, ($urandom_range(5) == 0) ? 0 : $urandom_range(12));
      len = int'(coord_dist(CW'(x0), CW'(x1)));
      if (int'(coord_dist(CW'(y0), CW'(y1))) > len) len = int'(coord_dist(CW'(y0), CW'(y1)));
      len++;
      if (pick < 84) steps = len;
      else if (pick < 92) steps = $urandom_range(0, len - 1);
      else steps = len + $urandom_range(1, 3);
    end
    draw_line(x0, y0, x1, y1, $urandom, steps);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int quota);
    int stop_at;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 4) send_step();
      else random_line();
      // Now and then let the engine run completely dry mid-phase.
      if ($urandom_range(99) < 2) wait_for_pixels();
    end
    wait_for_pixels();
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_BEGIN;
    x_start = '0;
    y_start = '0;
    x_end = '0;
    y_end = '0;
    pen_color = '0;
    out_ready = 1'b0;
    send_idle_pct = 31;
    recv_idle_pct = 74;
    error_count = 0;
    items_sent = 0;
    lines_begun = 0;
    pixels_checked = 0;
    ln_busy = 1'b0;
    ln_steep = 1'b0;
    ln_down = 1'b0;
    ln_major = '0;
    ln_major_end = '0;
    ln_minor = '0;
    ln_span = '0;
    ln_minor2 = '0;
    ln_err = 0;
    ln_color = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_idle_steps();
    test_point_lines();
    test_axis_lines();
    test_diagonals_and_abandon();
    wait_for_pixels();

    // Three handshake mixes: slow receiver, slow sender, then full speed.
    test_random_traffic(31, 74, 330);
    test_random_traffic(74, 31, 330);
    test_random_traffic(0, 0, 330);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pixel_q.size() != 0) report_mismatch("pixels never delivered", 0, 32'(pixel_q.size()));

    $display("Sent %0d input transfers (%0d lines begun) and checked %0d pixels,",
             items_sent, lines_begun, pixels_checked);
    $display("covering idle steps, point, axis, diagonal, steep and abandoned lines.");
    if (error_count == 0) begin
      $display("line_rasterizer_tb: PASS");
    end else begin
      $display("%0d mismatches", error_count);
      $display("line_rasterizer_tb: FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d pixels still expected", pixel_q.size());
    $display("line_rasterizer_tb: FAIL");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/lr_pkg.sv
sv/lr_front.sv
sv/lr_queue.sv
sv/lr_back.sv
sv/line_rasterizer.sv
verif/line_rasterizer_tb.sv
